@@ hw/rtl/sfsp_pkg.sv @@
// ----------------------------------------------------------------------------
// sfsp_pkg: shared definitions for the serial frame to servo PWM block
// Event codes, register indexes, field widths and the command scaling.
// ----------------------------------------------------------------------------
package sfsp_pkg;

	localparam int OP_W    = 2;
	localparam int BYTE_W  = 8;
	localparam int BASE_W  = 10;
	localparam int PER_W   = 12;
	localparam int LIM_W   = 4;
	localparam int WIDTH_W = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	// Event codes
	localparam logic [OP_W-1:0] OP_BYTE     = 2'd0;
	localparam logic [OP_W-1:0] OP_PWM_TICK = 2'd1;
	localparam logic [OP_W-1:0] OP_FAILSAFE = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_BASE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_CENTER   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TICKS   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FAILSAFE_LIMIT = 2'd3;

	localparam logic [BASE_W-1:0] PULSE_BASE_RST     = 10'd100;
	localparam logic [BASE_W-1:0] PULSE_CENTER_RST   = 10'd150;
	localparam logic [PER_W-1:0]  PERIOD_TICKS_RST   = 12'd1000;
	localparam logic [LIM_W-1:0]  FAILSAFE_LIMIT_RST = 4'd5;
	localparam logic [WIDTH_W-1:0] WIDTH_RST         = 11'd150;
	localparam logic [LIM_W-1:0]  SILENCE_MAX        = 4'd15;

	localparam logic [BYTE_W-1:0] SYNC_A = 8'hFF;
	localparam logic [BYTE_W-1:0] SYNC_B = 8'hFE;
	localparam logic [BYTE_W-1:0] SYNC_C = 8'hFD;

	localparam logic [10:0] CMD_MAX  = 11'd2047;
	localparam logic [6:0]  CMD_SPAN = 7'd100;

	// base + floor(min(v, 2047) * 100 / 2047). The quotient by 2047 comes from
	// a shift by 11 and one correction step, as x = q0*2047 + (q0 + x mod 2048).
	function automatic logic [WIDTH_W-1:0] cmd_to_width(
		input logic [BYTE_W-1:0] hi,
		input logic [BYTE_W-1:0] lo,
		input logic [BASE_W-1:0] base
	);
		logic [15:0] v;
		logic [10:0] vc;
		logic [17:0] x;
		logic [6:0]  q0;
		logic [11:0] r;
		logic [6:0]  q;
		v  = {hi, lo};
		vc = (v > {5'd0, CMD_MAX}) ? CMD_MAX : v[10:0];
		x  = {7'd0, vc} * {11'd0, CMD_SPAN};
		q0 = x[17:11];
		r  = {1'b0, x[10:0]} + {5'd0, q0};
		q  = (r >= {1'b0, CMD_MAX}) ? q0 + 7'd1 : q0;
		return {1'b0, base} + {4'd0, q};
	endfunction

endpackage

@@ hw/rtl/sfsp_item_if.sv @@
// ----------------------------------------------------------------------------
// sfsp_item_if: event channel
// Carries one event (kind and received byte) with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sfsp_item_if;
	logic                          valid;
	logic                          ready;
	logic [sfsp_pkg::OP_W-1:0]     op;
	logic [sfsp_pkg::BYTE_W-1:0]   rx_byte;

	modport source (output valid, output op, output rx_byte, input ready);
	modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

@@ hw/rtl/sfsp_result_if.sv @@
// ----------------------------------------------------------------------------
// sfsp_result_if: result channel
// Carries the pin levels, frame flag and pending targets of one event.
// ----------------------------------------------------------------------------
interface sfsp_result_if;
	logic                           valid;
	logic                           ready;
	logic                           ch1_level;
	logic                           ch2_level;
	logic                           frame_accepted;
	logic [sfsp_pkg::WIDTH_W-1:0]   ch1_target;
	logic [sfsp_pkg::WIDTH_W-1:0]   ch2_target;

	modport source (output valid, output ch1_level, output ch2_level,
		output frame_accepted, output ch1_target, output ch2_target, input ready);
	modport sink   (input valid, input ch1_level, input ch2_level,
		input frame_accepted, input ch1_target, input ch2_target, output ready);
endinterface

@@ hw/rtl/sfsp_cfg_if.sv @@
// ----------------------------------------------------------------------------
// sfsp_cfg_if: configuration write channel
// Carries a register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sfsp_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [sfsp_pkg::CFG_IDX_W-1:0]    index;
	logic [sfsp_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/serial_frame_to_servo_pwm.sv @@
// ----------------------------------------------------------------------------
// serial_frame_to_servo_pwm: serial frame decoder driving two servo channels
// The block takes one event per clock cycle unless the result side stalls it,
// and returns one result for each, through an input register and then a
// result register; the event logic and its state sit between the two, so a
// new event can enter each cycle when not stalled while the result register
// keeps the output side decoupled. Received bytes are searched for FF FE FD,
// a frame of FRAME_LEN bytes with an FD FE FF trailer sets the two channel
// targets, PWM ticks produce the pin levels and latch the targets at the end
// of each period, and failsafe ticks recentre the targets when frames stop.
// Configuration writes are always accepted and take effect at once.
// ----------------------------------------------------------------------------
module serial_frame_to_servo_pwm #(
	parameter int FRAME_LEN = 38
) (
	input  logic                 clk,
	input  logic                 arst_n,
	sfsp_item_if.sink            item,
	sfsp_result_if.source        result,
	sfsp_cfg_if.sink             cfg
);

	localparam int IDX_W = $clog2(FRAME_LEN + 1);
	localparam logic [IDX_W-1:0] IDX_FIRST    = IDX_W'(3);
	localparam logic [IDX_W-1:0] IDX_TRAIL_A  = IDX_W'(FRAME_LEN - 3);
	localparam logic [IDX_W-1:0] IDX_TRAIL_B  = IDX_W'(FRAME_LEN - 2);
	localparam logic [IDX_W-1:0] IDX_END      = IDX_W'(FRAME_LEN);

	// Configuration registers
	logic [sfsp_pkg::BASE_W-1:0]  pulse_base_q;
	logic [sfsp_pkg::BASE_W-1:0]  pulse_center_q;
	logic [sfsp_pkg::PER_W-1:0]   period_ticks_q;
	logic [sfsp_pkg::LIM_W-1:0]   failsafe_limit_q;

	// Input register
	logic                          valid_s1;
	logic [sfsp_pkg::OP_W-1:0]     op_s1;
	logic [sfsp_pkg::BYTE_W-1:0]   rx_byte_s1;

	// Result register
	logic                          valid_s2;
	logic                          ch1_level_s2;
	logic                          ch2_level_s2;
	logic                          frame_accepted_s2;
	logic [sfsp_pkg::WIDTH_W-1:0]  ch1_target_s2;
	logic [sfsp_pkg::WIDTH_W-1:0]  ch2_target_s2;

	// Event state
	logic                          in_frame_q, in_frame_n;
	logic [IDX_W-1:0]              byte_index_q, byte_index_n;
	logic [sfsp_pkg::BYTE_W-1:0]   recent_q [3];
	logic [sfsp_pkg::BYTE_W-1:0]   payload_q [4];
	logic [1:0]                    trailer_q, trailer_n;
	logic [sfsp_pkg::WIDTH_W-1:0]  target1_q, target1_n, target2_q, target2_n;
	logic [sfsp_pkg::WIDTH_W-1:0]  active1_q, active1_n, active2_q, active2_n;
	logic [sfsp_pkg::PER_W-1:0]    tick_q, tick_n;
	logic [sfsp_pkg::LIM_W-1:0]    silence_q, silence_n;

	logic                          advance;
	logic                          lv1, lv2, accepted;
	logic                          start, frame_on, shift_recent;
	logic [IDX_W-1:0]              idx_cur, idx_nxt;
	logic [3:0]                    payload_we;
	logic [sfsp_pkg::PER_W:0]      count;
	logic [sfsp_pkg::WIDTH_W-1:0]  cmd1_width, cmd2_width;

	assign advance     = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready  = !valid_s1 || advance;
	assign cfg.ready   = 1'b1;

	assign result.valid          = valid_s2;
	assign result.ch1_level      = ch1_level_s2;
	assign result.ch2_level      = ch2_level_s2;
	assign result.frame_accepted = frame_accepted_s2;
	assign result.ch1_target     = ch1_target_s2;
	assign result.ch2_target     = ch2_target_s2;

	assign cmd1_width = sfsp_pkg::cmd_to_width(payload_q[0], payload_q[1], pulse_base_q);
	assign cmd2_width = sfsp_pkg::cmd_to_width(payload_q[2], payload_q[3], pulse_base_q);

	assign start    = !in_frame_q && recent_q[0] == sfsp_pkg::SYNC_C &&
		recent_q[1] == sfsp_pkg::SYNC_B && recent_q[2] == sfsp_pkg::SYNC_A;
	assign frame_on = in_frame_q || start;
	assign idx_cur  = start ? IDX_FIRST : byte_index_q;
	assign idx_nxt  = idx_cur + IDX_W'(1);
	assign count    = {1'b0, tick_q} + {{sfsp_pkg::PER_W{1'b0}}, 1'b1};

	always_comb begin
		in_frame_n   = in_frame_q;
		byte_index_n = byte_index_q;
		trailer_n    = trailer_q;
		target1_n    = target1_q;
		target2_n    = target2_q;
		active1_n    = active1_q;
		active2_n    = active2_q;
		tick_n       = tick_q;
		silence_n    = silence_q;
		payload_we   = 4'd0;
		shift_recent = 1'b0;
		lv1          = 1'b0;
		lv2          = 1'b0;
		accepted     = 1'b0;
		if (advance) begin
			case (op_s1)
				sfsp_pkg::OP_BYTE: begin
					shift_recent = 1'b1;
					if (frame_on) begin
						for (int i = 0; i < 4; i++) begin
							payload_we[i] = (idx_cur == IDX_FIRST + IDX_W'(i));
						end
						// The trailer count seen on the last byte is the one left by
						// the byte before, so it is taken from the register.
						if (start) begin
							trailer_n = 2'd0;
						end
						if (idx_cur == IDX_TRAIL_A) begin
							trailer_n = (rx_byte_s1 == sfsp_pkg::SYNC_C) ? 2'd1 : 2'd0;
						end else if (idx_cur == IDX_TRAIL_B) begin
							trailer_n = (trailer_q == 2'd1 && rx_byte_s1 == sfsp_pkg::SYNC_B) ?
								2'd2 : 2'd0;
						end
						byte_index_n = idx_nxt;
						in_frame_n   = 1'b1;
						if (idx_nxt == IDX_END) begin
							in_frame_n = 1'b0;
							trailer_n  = 2'd0;
							if (trailer_q == 2'd2 && rx_byte_s1 == sfsp_pkg::SYNC_A) begin
								accepted  = 1'b1;
								silence_n = '0;
								target1_n = cmd1_width;
								target2_n = cmd2_width;
							end
						end
					end
				end
				sfsp_pkg::OP_PWM_TICK: begin
					lv1 = count < {2'd0, active1_q};
					lv2 = count < {2'd0, active2_q};
					if (count >= {1'b0, period_ticks_q}) begin
						active1_n = target1_q;
						active2_n = target2_q;
						tick_n    = '0;
					end else begin
						tick_n = count[sfsp_pkg::PER_W-1:0];
					end
				end
				sfsp_pkg::OP_FAILSAFE: begin
					if (silence_q > failsafe_limit_q) begin
						target1_n = {1'b0, pulse_center_q};
						target2_n = {1'b0, pulse_center_q};
					end
					if (silence_q != sfsp_pkg::SILENCE_MAX) begin
						silence_n = silence_q + 4'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_base_q     <= sfsp_pkg::PULSE_BASE_RST;
			pulse_center_q   <= sfsp_pkg::PULSE_CENTER_RST;
			period_ticks_q   <= sfsp_pkg::PERIOD_TICKS_RST;
			failsafe_limit_q <= sfsp_pkg::FAILSAFE_LIMIT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				sfsp_pkg::REG_PULSE_BASE:     pulse_base_q     <= cfg.data[sfsp_pkg::BASE_W-1:0];
				sfsp_pkg::REG_PULSE_CENTER:   pulse_center_q   <= cfg.data[sfsp_pkg::BASE_W-1:0];
				sfsp_pkg::REG_PERIOD_TICKS:   period_ticks_q   <= cfg.data[sfsp_pkg::PER_W-1:0];
				sfsp_pkg::REG_FAILSAFE_LIMIT: failsafe_limit_q <= cfg.data[sfsp_pkg::LIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			op_s1      <= item.op;
			rx_byte_s1 <= item.rx_byte;
		end
		if (advance) begin
			ch1_level_s2      <= lv1;
			ch2_level_s2      <= lv2;
			frame_accepted_s2 <= accepted;
			ch1_target_s2     <= target1_n;
			ch2_target_s2     <= target2_n;
		end
		for (int i = 0; i < 4; i++) begin
			if (payload_we[i]) begin
				payload_q[i] <= rx_byte_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			byte_index_q <= '0;
			recent_q[0]  <= '0;
			recent_q[1]  <= '0;
			recent_q[2]  <= '0;
			trailer_q    <= 2'd0;
			target1_q    <= sfsp_pkg::WIDTH_RST;
			target2_q    <= sfsp_pkg::WIDTH_RST;
			active1_q    <= sfsp_pkg::WIDTH_RST;
			active2_q    <= sfsp_pkg::WIDTH_RST;
			tick_q       <= '0;
			silence_q    <= '0;
		end else begin
			in_frame_q   <= in_frame_n;
			byte_index_q <= byte_index_n;
			trailer_q    <= trailer_n;
			target1_q    <= target1_n;
			target2_q    <= target2_n;
			active1_q    <= active1_n;
			active2_q    <= active2_n;
			tick_q       <= tick_n;
			silence_q    <= silence_n;
			if (shift_recent) begin
				recent_q[2] <= recent_q[1];
				recent_q[1] <= recent_q[0];
				recent_q[0] <= rx_byte_s1;
			end
		end
	end

endmodule
